// ===== sv/rcfe_pkg.sv =====
// Shared constants, types and the CRC-8 helper for the RC channel frame encoder.
// Used by every module of the block; depends on nothing else.
package rcfe_pkg;

  localparam int unsigned BurstMax = 4;

  localparam logic [7:0] SyncByte  = 8'hC8;
  localparam logic [7:0] LenByte   = 8'd24;
  localparam logic [7:0] TypeByte  = 8'h16;
  localparam logic [7:0] CrcPoly   = 8'hD5;
  localparam logic [3:0] LastChan  = 4'd15;

  localparam logic [15:0] UsMin    = 16'd1000;
  localparam logic [15:0] UsMax    = 16'd2000;
  localparam logic [9:0]  SpanMax  = 10'd1000;
  // ceil(1639 * 2^20 / 1000): exact floor(x * 1639 / 1000) for x up to 1000.
  localparam logic [20:0] ScaleMul = 21'd1718617;
  localparam int unsigned ScaleSh  = 20;
  localparam logic [10:0] RawOffs  = 11'd172;

  // One whole result group of an input item; bytes[0] leaves first.
  typedef struct packed {
    logic [BurstMax-1:0][7:0] bytes;
    logic [2:0]               n;
    logic                     last;
  } burst_t;

  // CRC-8, MSB first, over one byte with the CRC already folded in.
  function automatic logic [7:0] crc8_step(input logic [7:0] val);
    logic [7:0] c;
    c = val;
    for (int b = 0; b < 8; b++) begin
      if (c[7]) begin
        c = (c << 1) ^ CrcPoly;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

  localparam logic [7:0] CrcAfterType = crc8_step(TypeByte);

endpackage

// ===== sv/rcfe_map.sv =====
// Saturates a pulse width and maps it to the 11-bit raw channel value.
// Depends on rcfe_pkg.
module rcfe_map import rcfe_pkg::*; (
  input  logic [15:0] channel_us_i,
  output logic [10:0] raw_o
);

  logic [9:0]  span;
  logic [30:0] prod;

  always_comb begin
    if (channel_us_i < UsMin) begin
      span = '0;
    end else if (channel_us_i > UsMax) begin
      span = SpanMax;
    end else begin
      span = 10'(channel_us_i - UsMin);
    end
  end

  // Division by 1000 is done by the reciprocal folded into the scale factor.
  assign prod  = 31'(span) * 31'(ScaleMul);
  assign raw_o = prod[30:ScaleSh] + RawOffs;

endmodule

// ===== sv/rcfe_packer.sv =====
// Bit packer and running CRC: turns one raw channel value into its group of
// frame bytes and keeps the frame state. Depends on rcfe_pkg.
module rcfe_packer import rcfe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  logic [10:0] raw_i,
  output burst_t      burst_o
);

  logic [3:0] chan_q, chan_d;
  logic [6:0] pend_q, pend_d;
  logic [2:0] pcnt_q, pcnt_d;
  logic [7:0] crc_q,  crc_d;

  logic        hdr, last, two;
  logic [2:0]  cnt;
  logic [6:0]  bits, mask;
  logic [17:0] acc;
  logic [4:0]  total;
  logic [7:0]  b0, b1, crc_in, c1, c2;

  always_comb begin
    hdr    = (chan_q == '0);
    last   = (chan_q == LastChan);
    cnt    = hdr ? 3'd0 : pcnt_q;
    mask   = 7'((8'd1 << cnt) - 8'd1);
    bits   = hdr ? 7'd0 : (pend_q & mask);
    acc    = 18'(bits) | (18'(raw_i) << cnt);
    total  = 5'(cnt) + 5'd11;
    two    = (total >= 5'd16);
    b0     = acc[7:0];
    b1     = acc[15:8];
    crc_in = hdr ? CrcAfterType : crc_q;
    c1     = crc8_step(crc_in ^ b0);
    c2     = two ? crc8_step(c1 ^ b1) : c1;

    burst_o.last = last;
    if (hdr) begin
      // The first channel of a frame always fills exactly one payload byte.
      burst_o.bytes[0] = SyncByte;
      burst_o.bytes[1] = LenByte;
      burst_o.bytes[2] = TypeByte;
      burst_o.bytes[3] = b0;
      burst_o.n        = 3'd4;
    end else begin
      burst_o.bytes[0] = b0;
      burst_o.bytes[1] = two ? b1 : c2;
      burst_o.bytes[2] = c2;
      burst_o.bytes[3] = '0;
      burst_o.n        = (two ? 3'd2 : 3'd1) + (last ? 3'd1 : 3'd0);
    end

    if (last) begin
      chan_d = '0;
      crc_d  = '0;
      pend_d = '0;
      pcnt_d = '0;
    end else begin
      chan_d = chan_q + 4'd1;
      crc_d  = c2;
      pend_d = two ? 7'(acc[17:16]) : acc[14:8];
      pcnt_d = two ? 3'(total - 5'd16) : 3'(total - 5'd8);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q <= '0;
      pend_q <= '0;
      pcnt_q <= '0;
      crc_q  <= '0;
    end else if (load_i) begin
      chan_q <= chan_d;
      pend_q <= pend_d;
      pcnt_q <= pcnt_d;
      crc_q  <= crc_d;
    end
  end

endmodule

// ===== sv/rcfe_obuf.sv =====
// Result register: holds one item's group of bytes and hands them out one per
// transfer. Depends on rcfe_pkg.
module rcfe_obuf import rcfe_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  burst_t     burst_i,
  output logic       free_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] frame_byte_o,
  output logic       frame_end_o
);

  logic [BurstMax-1:0][7:0] bytes_q;
  logic [2:0]               cnt_q;
  logic                     last_q;
  logic                     pop;

  assign out_valid_o  = (cnt_q != '0);
  assign pop          = out_valid_o && out_ready_i;
  // A new group may enter when the buffer is empty or its final byte leaves now.
  assign free_o       = (cnt_q == 3'd0) || ((cnt_q == 3'd1) && out_ready_i);
  assign frame_byte_o = bytes_q[0];
  assign frame_end_o  = last_q && (cnt_q == 3'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= burst_i.n;
    end else if (pop) begin
      cnt_q <= cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bytes_q <= burst_i.bytes;
      last_q  <= burst_i.last;
    end else if (pop) begin
      for (int i = 0; i < BurstMax - 1; i++) begin
        bytes_q[i] <= bytes_q[i+1];
      end
    end
  end

endmodule

// ===== sv/rc_channel_frame_encoder.sv =====
// RC channel frame encoder, top level: input register, raw mapping, packer
// with CRC, and the result register. Depends on rcfe_pkg and its submodules.
// Path: an item passes the input register, then the result register once it is free.
// Output: one frame byte per cycle while out_ready_i is high; an item yields 1 to 4
// bytes (26 bytes per 16 channels), and the next item loads as its last byte leaves.
// Reset: asynchronous, active low; starts a new frame with empty buffers.
module rc_channel_frame_encoder import rcfe_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] channel_us_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  frame_byte_o,
  output logic        frame_end_o
);

  logic        in_valid_q;
  logic [15:0] channel_us_q;
  logic [10:0] raw;
  logic        free, load;
  burst_t      burst;

  assign load       = in_valid_q && free;
  assign in_ready_o = !in_valid_q || load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      channel_us_q <= channel_us_i;
    end
  end

  rcfe_map u_map (
    .channel_us_i (channel_us_q),
    .raw_o        (raw)
  );

  rcfe_packer u_packer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (load),
    .raw_i   (raw),
    .burst_o (burst)
  );

  rcfe_obuf u_obuf (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (load),
    .burst_i      (burst),
    .free_o       (free),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .frame_byte_o (frame_byte_o),
    .frame_end_o  (frame_end_o)
  );

endmodule
